### src/gcc_pkg.sv
// Shared widths, register indexes and reset values for the greedy coin change unit.
package gcc_pkg;

   // Field widths
   localparam int AMOUNT_W    = 16;   // change_amount input field
   localparam int DENOM_W     = 16;   // one denomination register
   localparam int COUNT_W     = 16;   // coin_count and leftover result fields
   localparam int IDX_W       = 3;    // denom_index field and denoms_in_use register
   localparam int NUM_DENOM_REGS = 6;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_DENOMS  = 6;
   localparam int DEF_AMOUNT_BITS = 16;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_DENOMS_IN_USE = 3'd0;
   localparam logic [IDX_W-1:0] REG_DENOM_FIRST   = 3'd1;
   localparam logic [IDX_W-1:0] REG_DENOM_LAST    = 3'd6;

   // Reset values
   localparam logic [IDX_W-1:0] RST_DENOMS_IN_USE = 3'd6;

   typedef logic [NUM_DENOM_REGS-1:0][DENOM_W-1:0] denom_array_type;

   localparam denom_array_type RST_DENOMS = {16'd1, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100};

   // Divider result handed back to the sequencer
   typedef struct packed {
      logic               done;
      logic [AMOUNT_W-1:0] quotient;
      logic [AMOUNT_W-1:0] remainder;
   } div_result_type;

endpackage

### src/gcc_csr.sv
// Configuration registers: denomination count and the six denomination values.
module gcc_csr
   import gcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [DENOM_W-1:0] csr_data,
   output logic [IDX_W-1:0]   denoms_in_use,
   output denom_array_type    denoms
);

   logic [IDX_W-1:0] count_ff;
   denom_array_type  denoms_ff;
   logic             wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= RST_DENOMS_IN_USE;
         denoms_ff <= RST_DENOMS;
      end else if (wr_en) begin
         if (csr_index == REG_DENOMS_IN_USE) begin
            count_ff <= csr_data[IDX_W-1:0];
         end else if (csr_index inside {[REG_DENOM_FIRST:REG_DENOM_LAST]}) begin
            denoms_ff[csr_index - REG_DENOM_FIRST] <= csr_data;
         end
      end
   end

   assign denoms_in_use = count_ff;
   assign denoms        = denoms_ff;

endmodule

### src/gcc_divider.sv
// Restoring divider: one quotient bit per cycle through a shift register.
module gcc_divider
   import gcc_pkg::*;
#(
   parameter int WIDTH = DEF_AMOUNT_BITS
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   dividend,
   input  logic [DENOM_W-1:0] divisor,
   output div_result_type     result
);

   localparam int RW    = DENOM_W + 1;
   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [RW-1:0]      rem_ff, rem_in;
   logic [WIDTH-1:0]   quo_ff, quo_in;
   logic [DENOM_W-1:0] dsr_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [RW-1:0]      shifted;
   logic [RW:0]        diff;
   logic               ge;

   // One restoring step: shift in the next dividend bit, try to subtract
   always_comb begin
      shifted = {rem_ff[RW-2:0], quo_ff[WIDTH-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      ge      = !diff[RW];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(WIDTH);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[RW-1:0] : shifted;
         quo_in  = {quo_ff[WIDTH-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   // Remainder never exceeds the dividend, so it fits in WIDTH bits
   assign result.done      = done_ff;
   assign result.quotient  = AMOUNT_W'(quo_ff);
   assign result.remainder = AMOUNT_W'(rem_ff[WIDTH-1:0]);

endmodule

### src/greedy_coin_change_unit.sv
// Greedy coin change unit: walks the denominations in index order, one result each.
// Each result comes from the shared divider, one bit per cycle over AW bits
// (AW = amount width, min(AMOUNT_BITS,16)). One amount is in flight at a time:
// a new amount is taken only after the last result of the one before is accepted.
// Reset: synchronous, active high; clears control and loads default denominations.
module greedy_coin_change_unit
   import gcc_pkg::*;
#(
   parameter int MAX_DENOMS  = DEF_MAX_DENOMS,
   parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
)
(
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // [15:0] change_amount
   // result items
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,   // [15:0] coin_count, [31:16] leftover,
                                           // [32] no_solution, [39:33] zero
   output logic [IDX_W-1:0]   rsp_tuser,   // [2:0] denom_index
   output logic               rsp_tlast,   // last
   // configuration writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [DENOM_W-1:0] csr_data
);

   localparam int AW = (AMOUNT_BITS < AMOUNT_W) ? AMOUNT_BITS : AMOUNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [AW-1:0]      amount_ff, amount_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] coins_ff, coins_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic               nosol_ff, nosol_in;
   logic               last_ff, last_in;

   logic [IDX_W-1:0]   cfg_count;
   denom_array_type    denoms;
   logic [IDX_W-1:0]   last_idx;
   logic               req_acc, rsp_acc;
   logic               div_start;
   logic [AW-1:0]      div_dividend;
   logic [DENOM_W-1:0] div_divisor;
   div_result_type     div_res;
   logic               cur_zero;
   logic [AW-1:0]      new_amount;

   gcc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .denoms_in_use (cfg_count),
      .denoms        (denoms)
   );

   gcc_divider #(.WIDTH(AW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // Clamp the denomination count to 1..MAX_DENOMS
   always_comb begin
      if (cfg_count == '0) begin
         last_idx = '0;
      end else if (cfg_count > IDX_W'(MAX_DENOMS)) begin
         last_idx = IDX_W'(MAX_DENOMS - 1);
      end else begin
         last_idx = cfg_count - 1'b1;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_valid_ff && rsp_tready;

   // A zero denomination pays nothing and passes the amount through
   assign cur_zero   = (denoms[idx_ff] == '0);
   assign new_amount = cur_zero ? amount_ff : div_res.remainder[AW-1:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      amount_in    = amount_ff;
      rsp_valid_in = rsp_valid_ff;
      coins_in     = coins_ff;
      left_in      = left_ff;
      nosol_in     = nosol_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      div_dividend = amount_ff;
      div_divisor  = denoms[idx_ff];
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               div_start    = 1'b1;
               div_dividend = req_tdata[AW-1:0];
               div_divisor  = denoms[0];
               amount_in    = req_tdata[AW-1:0];
               idx_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               amount_in    = new_amount;
               coins_in     = cur_zero ? '0 : div_res.quotient;
               left_in      = COUNT_W'(new_amount);
               last_in      = (idx_ff == last_idx);
               nosol_in     = (idx_ff == last_idx) && (new_amount != '0);
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in      = idx_ff + 1'b1;
                  div_start   = 1'b1;
                  div_divisor = denoms[idx_ff + 1'b1];
                  state_in    = ST_DIV;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      amount_ff <= amount_in;
      coins_ff  <= coins_in;
      left_ff   <= left_in;
      nosol_ff  <= nosol_in;
      last_ff   <= last_in;
   end

   // Result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, nosol_ff, left_ff, coins_ff};
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = last_ff;

   // Checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while a result is pending");

   a_nosol_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |-> (rsp_tlast && rsp_tdata[31:16] != 16'd0))
      else $error("no_solution outside the last result or with zero leftover");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser < IDX_W'(MAX_DENOMS)))
      else $error("denomination index beyond the configured maximum");

   a_run_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (rsp_tuser == '0 && !rsp_tvalid))
      else $error("run did not start at the first denomination");

endmodule

### sim/tb_top.sv
// Testbench for the greedy coin change unit: table-driven and random amounts checked item by item.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gcc_pkg::*;

   localparam int CLK_PERIOD      = 20;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 2 * (AMOUNT_W + 2);
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 24;

   // register index that decodes to nothing
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   // one coin-split result as it leaves the block
   typedef struct packed {
      logic [IDX_W-1:0]   denom_index;
      logic [COUNT_W-1:0] coin_count;
      logic [COUNT_W-1:0] leftover;
      logic               no_solution;
      logic               last;
   } coin_result_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_TYPED} row_kind_type;

   // directed stimulus row: a register write, a predicted item or an item with a typed result
   typedef struct packed {
      row_kind_type       kind;
      logic [IDX_W-1:0]   index;
      logic [DENOM_W-1:0] value;
      coin_result_type    typed;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic [IDX_W-1:0]    rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [DENOM_W-1:0]  csr_data = '0;

   // shadow of the register file, updated on each accepted write
   logic [IDX_W-1:0]    shadow_count;
   logic [DENOM_W-1:0]  shadow_denom [NUM_DENOM_REGS];

   coin_result_type     owed_coins [$];
   script_row_type      script [$];
   int                  mismatch_count = 0;
   int                  tx_idle_pct = 0;
   int                  rx_stall_pct = 0;
   logic                rx_hold = 1'b0;
   logic                hold_armed = 1'b0;

   greedy_coin_change_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // greedy walk over the shadow denominations, one expected result per denomination
   function automatic void predict_coin_split(input logic [AMOUNT_W-1:0] amount);
      coin_result_type     r;
      int                  n;
      logic [AMOUNT_W-1:0] rest;
      logic [DENOM_W-1:0]  d;
      n = shadow_count;
      if (n < 1) n = 1;
      if (n > DEF_MAX_DENOMS) n = DEF_MAX_DENOMS;
      rest = amount;
      for (int i = 0; i < n; i++) begin
         d = shadow_denom[i];
         r.coin_count = '0;
         if (d != 0) begin
            r.coin_count = rest / d;
            rest = rest % d;
         end
         r.denom_index = i[IDX_W-1:0];
         r.leftover = rest;
         r.last = (i == n - 1);
         r.no_solution = r.last && (rest != 0);
         owed_coins.push_back(r);
      end
   endfunction

   function automatic void table_write(input logic [IDX_W-1:0] index,
                                       input logic [DENOM_W-1:0] value);
      script_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.index = index;
      row.value = value;
      script.push_back(row);
   endfunction

   function automatic void table_item(input logic [AMOUNT_W-1:0] amount);
      script_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.value = amount;
      script.push_back(row);
   endfunction

   // typed rows run with a single denomination, so the run is one result
   function automatic void table_typed(input logic [AMOUNT_W-1:0] amount,
                                       input logic [COUNT_W-1:0] coins,
                                       input logic [COUNT_W-1:0] left,
                                       input logic nosol);
      script_row_type row;
      row = '0;
      row.kind = ROW_TYPED;
      row.value = amount;
      row.typed.coin_count = coins;
      row.typed.leftover = left;
      row.typed.no_solution = nosol;
      row.typed.last = 1'b1;
      script.push_back(row);
   endfunction

   // offer one amount, with random gaps ahead of it; returns at the accepting edge
   task automatic offer_amount(input logic [AMOUNT_W-1:0] amount, input logic use_typed,
                               input coin_result_type typed);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= amount;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (use_typed) owed_coins.push_back(typed);
      else predict_coin_split(amount);
   endtask

   // drop valid, wait until every owed result is in, then let the block settle
   task automatic wait_for_quiet(input int extra);
      req_tvalid <= 1'b0;
      while (owed_coins.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DENOM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_DENOMS_IN_USE) shadow_count = value[IDX_W-1:0];
      else if (index >= REG_DENOM_FIRST && index <= REG_DENOM_LAST)
         shadow_denom[index - REG_DENOM_FIRST] = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // result receiver: random stalls plus the long hold-off
   always @(posedge clock) begin
      if (rx_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
   end

   initial begin : rx_long_hold
      wait (hold_armed);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // result checker
   always @(posedge clock) begin
      coin_result_type got;
      coin_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.denom_index = rsp_tuser;
         got.coin_count = rsp_tdata[15:0];
         got.leftover = rsp_tdata[31:16];
         got.no_solution = rsp_tdata[32];
         got.last = rsp_tlast;
         if (owed_coins.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected item idx=%0d coins=%0d left=%0d nosol=%0b last=%0b",
                     $time, got.denom_index, got.coin_count, got.leftover,
                     got.no_solution, got.last);
         end else begin
            want = owed_coins.pop_front();
            if (got !== want) begin
               mismatch_count++;
               $display("%0t: mismatch expected idx=%0d coins=%0d left=%0d nosol=%0b last=%0b",
                        $time, want.denom_index, want.coin_count, want.leftover,
                        want.no_solution, want.last);
               $display("%0t:          actual   idx=%0d coins=%0d left=%0d nosol=%0b last=%0b",
                        $time, got.denom_index, got.coin_count, got.leftover,
                        got.no_solution, got.last);
            end
         end
      end
   end

   // watchdog: ends the run after too long without any accepted item
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // main sequence
   initial begin
      script_row_type      row;
      logic [AMOUNT_W-1:0] amount;
      logic [DENOM_W-1:0]  value;
      logic [DENOM_W-1:0]  prev;
      int                  style;
      int                  pick;

      shadow_count = RST_DENOMS_IN_USE;
      for (int i = 0; i < NUM_DENOM_REGS; i++) shadow_denom[i] = RST_DENOMS[i];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset denominations first
      table_item(16'd0);
      table_item(16'hFFFF);
      table_item(16'd188);
      table_item(16'd99);
      // single denomination: results typed in
      table_write(REG_DENOMS_IN_USE, 16'd1);
      table_write(REG_DENOM_FIRST, 16'hFFFF);
      table_typed(16'hFFFF, 16'd1, 16'd0, 1'b0);
      table_typed(16'hFFFE, 16'd0, 16'hFFFE, 1'b1);
      table_typed(16'd0, 16'd0, 16'd0, 1'b0);
      table_write(REG_DENOM_FIRST, 16'd1);
      table_typed(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
      // zero denomination passes the amount on
      table_write(REG_DENOM_FIRST, 16'd0);
      table_typed(16'hAAAA, 16'd0, 16'hAAAA, 1'b1);
      table_typed(16'd0, 16'd0, 16'd0, 1'b0);
      // count of zero runs one denomination
      table_write(REG_DENOMS_IN_USE, 16'd0);
      table_typed(16'h5555, 16'd0, 16'h5555, 1'b1);
      table_write(REG_DENOM_FIRST, 16'd7);
      table_typed(16'd50, 16'd7, 16'd1, 1'b1);
      // upper data bits of the count register are dropped
      table_write(REG_DENOMS_IN_USE, 16'hFFFA);
      table_item(16'd50);
      // count above the maximum, unknown index ignored
      table_write(REG_DENOMS_IN_USE, 16'd7);
      table_write(REG_UNUSED, 16'd1234);
      table_item(16'd1000);
      // denominations out of order
      table_write(REG_DENOM_FIRST + 3'd1, 16'h8000);
      table_item(16'hFFFF);
      table_item(16'd40000);
      // zero in the middle of the list
      table_write(REG_DENOM_FIRST + 3'd3, 16'd0);
      table_item(16'd40000);
      table_item(16'd12345);
      table_write(REG_DENOMS_IN_USE, 16'd3);
      table_item(16'hFFFF);
      table_item(16'd777);

      foreach (script[k]) begin
         row = script[k];
         case (row.kind)
            ROW_WRITE: begin
               wait_for_quiet(SETTLE_CYCLES);
               write_reg(row.index, row.value);
            end
            ROW_ITEM:  offer_amount(row.value, 1'b0, row.typed);
            default:   offer_amount(row.value, 1'b1, row.typed);
         endcase
      end

      // random part: a fresh setting per phase, idling varied across phases
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_quiet(SETTLE_CYCLES);
         value = 16'($urandom);
         value[IDX_W-1:0] = IDX_W'($urandom_range(7, 0));
         write_reg(REG_DENOMS_IN_USE, value);
         style = $urandom_range(3, 0);
         prev = (style == 0) ? 16'hFFFF : (style == 1) ? 16'd2000 : 16'd120;
         for (int i = 0; i < NUM_DENOM_REGS; i++) begin
            if (style == 3) begin
               value = ($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom);
            end else begin
               value = 16'($urandom_range(prev, 1));
               if (i == NUM_DENOM_REGS - 1 && $urandom_range(1, 0) == 1) value = 16'd1;
               prev = value;
            end
            write_reg(REG_DENOM_FIRST + i[IDX_W-1:0], value);
         end
         if (phase % 2 == 1) write_reg(REG_UNUSED, 16'($urandom));

         case (phase % 4)
            0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
            1: begin tx_idle_pct <= 49; rx_stall_pct <= 0;  end
            2: begin tx_idle_pct <= 0;  rx_stall_pct <= 49; end
            default: begin tx_idle_pct <= 16; rx_stall_pct <= 16; end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // receiver holds off while items keep coming
            if (phase == 0 && n == 3) hold_armed = 1'b1;
            // sender pauses until everything owed has come back
            if (phase == 5 && n == 13) wait_for_quiet(1);
            pick = $urandom_range(99, 0);
            if (pick < 50) amount = AMOUNT_W'($urandom);
            else if (pick < 85) amount = AMOUNT_W'($urandom_range(600, 0));
            else if (pick < 93) amount = 16'hFFFF;
            else amount = 16'd0;
            offer_amount(amount, 1'b0, '0);
         end
      end

      wait_for_quiet(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
src/gcc_pkg.sv
src/gcc_csr.sv
src/gcc_divider.sv
src/greedy_coin_change_unit.sv
sim/tb_top.sv
